/* rtl/bai_pkg.sv */
package bai_pkg;

   // default configuration of the block
   localparam int DEF_CANVAS_COLUMNS = 64;
   localparam int DEF_CANVAS_ROWS    = 64;
   localparam int DEF_MAX_SOURCE_DIM = 1536;

   // field widths
   localparam int PIX_W   = 8;
   localparam int COORD_W = 6;
   localparam int SUM_W   = 18;
   localparam int CNT_W   = 10;

   // register port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;
   localparam logic [CSR_IDX_W-1:0]  CSR_SOURCE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0]  CSR_SOURCE_HEIGHT = 1'b1;
   localparam logic [CSR_DATA_W-1:0] RESET_DIM         = 11'd64;

   // one column accumulator entry
   typedef struct packed {
      logic [SUM_W-1:0] red;
      logic [SUM_W-1:0] green;
      logic [SUM_W-1:0] blue;
      logic [CNT_W-1:0] count;
   } acc_entry_type;

   // controller to datapath
   typedef struct packed {
      logic sdiv_start;
      logic sdiv_sel;
      logic load_w;
      logic load_h;
      logic restart;
      logic accept;
      logic acc_write;
      logic em_init;
      logic em_read;
      logic div_start;
      logic out_load;
      logic next_col;
      logic next_row;
      logic clear_cols;
      logic advance;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic sdiv_done;
      logic acc_more;
      logic emit_needed;
      logic div_done;
      logic out_valid;
      logic out_taken;
      logic last_col;
      logic more_rows;
   } status_type;

endpackage

/* rtl/bai_req_if.sv */
interface bai_req_if;
   logic                      valid;
   logic                      ready;
   logic [bai_pkg::PIX_W-1:0] red_in;
   logic [bai_pkg::PIX_W-1:0] green_in;
   logic [bai_pkg::PIX_W-1:0] blue_in;

   modport source (output valid, output red_in, output green_in, output blue_in,
                   input ready);
   modport sink (input valid, input red_in, input green_in, input blue_in,
                 output ready);
endinterface

/* rtl/bai_rsp_if.sv */
interface bai_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bai_pkg::COORD_W-1:0] dest_x;
   logic [bai_pkg::COORD_W-1:0] dest_y;
   logic [bai_pkg::PIX_W-1:0]   red_out;
   logic [bai_pkg::PIX_W-1:0]   green_out;
   logic [bai_pkg::PIX_W-1:0]   blue_out;
   logic                        run_last;

   modport source (output valid, output dest_x, output dest_y, output red_out,
                   output green_out, output blue_out, output run_last, input ready);
   modport sink (input valid, input dest_x, input dest_y, input red_out,
                 input green_out, input blue_out, input run_last, output ready);
endinterface

/* rtl/box_average_image_resize.sv */
// Box-average resizer from a raster RGB888 source to a fixed canvas.
// req_chan takes one source pixel per transfer, in raster order; rsp_chan
// gives destination pixels (coordinates, averages, run_last) in row-then-
// column order. run_last marks the final result caused by one source pixel.
// The csr port writes source_width (index 0) and source_height (index 1);
// any write restarts the frame and reruns the span setup.
// Setup after reset or a register write: two reciprocal-multiply span
// steps with req ready low, then a frame restart that clears the
// accumulator valid bits, which reset also clears. Each covered canvas
// column adds an accumulator read-modify-write, a read state then a write
// state. Each result then goes through the 18-step serial divider and
// is held while the receiver holds rsp ready low.
// The block handles one pixel at a time: a result waits in the output
// register while rsp ready is low, and the next pixel is taken only after
// the last result of the current one has been transferred.
module box_average_image_resize #(
   parameter int CANVAS_COLUMNS = bai_pkg::DEF_CANVAS_COLUMNS,
   parameter int CANVAS_ROWS    = bai_pkg::DEF_CANVAS_ROWS,
   parameter int MAX_SOURCE_DIM = bai_pkg::DEF_MAX_SOURCE_DIM
) (
   input  logic                           clock,
   input  logic                           reset,
   bai_req_if.sink                        req_chan,
   bai_rsp_if.source                      rsp_chan,
   input  logic                           csr_write_enable,
   input  logic [bai_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bai_pkg::CSR_DATA_W-1:0] csr_write_data
);
   bai_pkg::cmd_type    cmd;
   bai_pkg::status_type status;
   logic                req_ready;

   assign req_chan.ready = req_ready;

   bai_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_chan.valid),
      .req_ready        (req_ready),
      .csr_write_enable (csr_write_enable),
      .status           (status),
      .cmd              (cmd)
   );

   bai_datapath #(
      .CANVAS_COLUMNS (CANVAS_COLUMNS),
      .CANVAS_ROWS    (CANVAS_ROWS),
      .MAX_SOURCE_DIM (MAX_SOURCE_DIM)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .red_in           (req_chan.red_in),
      .green_in         (req_chan.green_in),
      .blue_in          (req_chan.blue_in),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .dest_x           (rsp_chan.dest_x),
      .dest_y           (rsp_chan.dest_y),
      .red_out          (rsp_chan.red_out),
      .green_out        (rsp_chan.green_out),
      .blue_out         (rsp_chan.blue_out),
      .run_last         (rsp_chan.run_last)
   );
endmodule

/* rtl/bai_div.sv */
module bai_div #(
   parameter int NUM_W = 18,
   parameter int DEN_W = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo,
   output logic [DEN_W-1:0] rem
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] acc_ff, acc_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;

   // one restoring step per cycle
   always_comb begin
      trial   = {rem_ff, acc_ff[NUM_W-1]};
      ge      = trial >= {1'b0, den_ff};
      diff    = trial - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = CNT_W'(NUM_W);
         acc_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         acc_in = {acc_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = acc_ff;
   assign rem  = rem_ff;
endmodule

/* rtl/bai_datapath.sv */
module bai_datapath #(
   parameter int CANVAS_COLUMNS = bai_pkg::DEF_CANVAS_COLUMNS,
   parameter int CANVAS_ROWS    = bai_pkg::DEF_CANVAS_ROWS,
   parameter int MAX_SOURCE_DIM = bai_pkg::DEF_MAX_SOURCE_DIM
) (
   input  logic                            clock,
   input  logic                            reset,
   input  bai_pkg::cmd_type                cmd,
   output bai_pkg::status_type             status,
   input  logic [bai_pkg::PIX_W-1:0]       red_in,
   input  logic [bai_pkg::PIX_W-1:0]       green_in,
   input  logic [bai_pkg::PIX_W-1:0]       blue_in,
   input  logic                            csr_write_enable,
   input  logic [bai_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bai_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [bai_pkg::COORD_W-1:0]     dest_x,
   output logic [bai_pkg::COORD_W-1:0]     dest_y,
   output logic [bai_pkg::PIX_W-1:0]       red_out,
   output logic [bai_pkg::PIX_W-1:0]       green_out,
   output logic [bai_pkg::PIX_W-1:0]       blue_out,
   output logic                            run_last
);
   localparam int DIM_W  = $clog2(MAX_SOURCE_DIM + 1);
   localparam int CI_W   = $clog2(CANVAS_COLUMNS + 1);
   localparam int RI_W   = $clog2(CANVAS_ROWS + 1);
   localparam int CA_W   = $clog2(CANVAS_COLUMNS);
   localparam int CR_W   = $clog2(CANVAS_COLUMNS);
   localparam int RR_W   = $clog2(CANVAS_ROWS);
   localparam int MAXC   = (CANVAS_COLUMNS > CANVAS_ROWS) ? CANVAS_COLUMNS : CANVAS_ROWS;
   localparam int DEN_W  = $clog2(MAXC + 1);
   localparam int EXT_W  = (DIM_W > bai_pkg::CSR_DATA_W) ? DIM_W : bai_pkg::CSR_DATA_W;
   localparam int W_LO   = (CANVAS_COLUMNS + 7) / 8;
   localparam int H_LO   = (CANVAS_ROWS + 7) / 8;
   // reciprocals exact for every numerator below 2**DIM_W
   localparam int SH_C   = DIM_W + $clog2(CANVAS_COLUMNS);
   localparam int SH_R   = DIM_W + $clog2(CANVAS_ROWS);
   localparam int RCP_W  = DIM_W + 2;
   localparam int PROD_W = DIM_W + RCP_W;
   localparam int RCP_C  = (1 << SH_C) / CANVAS_COLUMNS + 1;
   localparam int RCP_R  = (1 << SH_R) / CANVAS_ROWS + 1;

   // configuration registers
   logic [bai_pkg::CSR_DATA_W-1:0] width_ff, height_ff;
   logic [EXT_W-1:0]               width_ext, height_ext;
   logic [DIM_W-1:0]               w_eff, h_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bai_pkg::RESET_DIM;
         height_ff <= bai_pkg::RESET_DIM;
      end else if (csr_write_enable) begin
         if (csr_index == bai_pkg::CSR_SOURCE_WIDTH) begin
            width_ff <= csr_write_data;
         end
         if (csr_index == bai_pkg::CSR_SOURCE_HEIGHT) begin
            height_ff <= csr_write_data;
         end
      end
   end

   // clamp dimensions into the supported range
   always_comb begin
      width_ext  = EXT_W'(width_ff);
      height_ext = EXT_W'(height_ff);
      if (width_ext < EXT_W'(W_LO)) begin
         w_eff = DIM_W'(W_LO);
      end else if (width_ext > EXT_W'(MAX_SOURCE_DIM)) begin
         w_eff = DIM_W'(MAX_SOURCE_DIM);
      end else begin
         w_eff = DIM_W'(width_ext);
      end
      if (height_ext < EXT_W'(H_LO)) begin
         h_eff = DIM_W'(H_LO);
      end else if (height_ext > EXT_W'(MAX_SOURCE_DIM)) begin
         h_eff = DIM_W'(MAX_SOURCE_DIM);
      end else begin
         h_eff = DIM_W'(height_ext);
      end
   end

   // span step: dimension divided by canvas size, quotient and remainder
   logic              sdiv_done;
   logic [DIM_W-1:0]  sdiv_quo;
   logic [DEN_W-1:0]  sdiv_rem;
   logic [DIM_W-1:0]  qw_ff, qh_ff;
   logic [CR_W-1:0]   rw_ff;
   logic [RR_W-1:0]   rh_ff;
   logic [DIM_W-1:0]  sdiv_num;
   logic [PROD_W-1:0] sdiv_prod;
   logic [DIM_W-1:0]  sdiv_q;
   logic [PROD_W-1:0] sdiv_back;
   logic              sdiv_done_ff;
   logic              sdiv_sel_ff;
   logic [DIM_W-1:0]  sdiv_num_ff, sdiv_quo_ff;

   // quotient by reciprocal multiply, remainder from the registered quotient
   always_comb begin
      sdiv_num = cmd.sdiv_sel ? h_eff : w_eff;
      if (cmd.sdiv_sel) begin
         sdiv_prod = PROD_W'(sdiv_num) * PROD_W'(RCP_R);
         sdiv_q    = DIM_W'(sdiv_prod >> SH_R);
      end else begin
         sdiv_prod = PROD_W'(sdiv_num) * PROD_W'(RCP_C);
         sdiv_q    = DIM_W'(sdiv_prod >> SH_C);
      end
      sdiv_back = PROD_W'(sdiv_quo_ff) *
                  (sdiv_sel_ff ? PROD_W'(CANVAS_ROWS) : PROD_W'(CANVAS_COLUMNS));
      sdiv_rem  = DEN_W'(PROD_W'(sdiv_num_ff) - sdiv_back);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sdiv_done_ff <= 1'b0;
      end else begin
         sdiv_done_ff <= cmd.sdiv_start;
      end
      if (cmd.sdiv_start) begin
         sdiv_num_ff <= sdiv_num;
         sdiv_quo_ff <= sdiv_q;
         sdiv_sel_ff <= cmd.sdiv_sel;
      end
   end

   assign sdiv_done = sdiv_done_ff;
   assign sdiv_quo  = sdiv_quo_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_w) begin
         qw_ff <= sdiv_quo;
         rw_ff <= CR_W'(sdiv_rem);
      end
      if (cmd.load_h) begin
         qh_ff <= sdiv_quo;
         rh_ff <= RR_W'(sdiv_rem);
      end
   end

   // position, column band and row band state
   logic [DIM_W-1:0] sx_ff, sy_ff;
   logic [CI_W-1:0]  col_ff, band0_ff, ex_ff;
   logic [DIM_W-1:0] clo_ff, chi_ff;
   logic [CR_W-1:0]  crem_ff;
   logic [RI_W-1:0]  row_ff, dy_ff;
   logic [DIM_W-1:0] rlo_ff, rhi_ff, tlo_ff, thi_ff;
   logic [RR_W-1:0]  rrem_ff, trem_ff;
   logic [bai_pkg::PIX_W-1:0] pr_ff, pg_ff, pb_ff;

   // next column boundary
   logic [CR_W:0]    crem_sum;
   logic             cwrap;
   logic [DIM_W-1:0] c_nhi, clast;
   logic [CR_W-1:0]  c_nrem;
   logic             col_finished;
   // next row boundary from the emission copy
   logic [RR_W:0]    trem_sum;
   logic             twrap;
   logic [DIM_W-1:0] t_nhi, t_nlast, rlast;
   logic [RR_W-1:0]  t_nrem;
   logic             row_done;
   logic             sx_wrap, sy_wrap;

   always_comb begin
      crem_sum     = {1'b0, crem_ff} + {1'b0, rw_ff};
      cwrap        = crem_sum >= (CR_W + 1)'(CANVAS_COLUMNS);
      c_nhi        = chi_ff + qw_ff + DIM_W'(cwrap);
      c_nrem       = cwrap ? CR_W'(crem_sum - (CR_W + 1)'(CANVAS_COLUMNS)) : CR_W'(crem_sum);
      clast        = (chi_ff > clo_ff) ? chi_ff - 1'b1 : clo_ff;
      col_finished = clast == sx_ff;

      trem_sum = {1'b0, trem_ff} + {1'b0, rh_ff};
      twrap    = trem_sum >= (RR_W + 1)'(CANVAS_ROWS);
      t_nhi    = thi_ff + qh_ff + DIM_W'(twrap);
      t_nrem   = twrap ? RR_W'(trem_sum - (RR_W + 1)'(CANVAS_ROWS)) : RR_W'(trem_sum);
      t_nlast  = (t_nhi > thi_ff) ? t_nhi - 1'b1 : thi_ff;
      rlast    = (rhi_ff > rlo_ff) ? rhi_ff - 1'b1 : rlo_ff;
      row_done = rlast == sy_ff;

      sx_wrap = (sx_ff + 1'b1) == w_eff;
      sy_wrap = (sy_ff + 1'b1) == h_eff;
   end

   always_ff @(posedge clock) begin
      // frame restart puts every band at its first column and row
      if (cmd.restart) begin
         sx_ff   <= '0;
         sy_ff   <= '0;
         col_ff  <= '0;
         clo_ff  <= '0;
         chi_ff  <= qw_ff;
         crem_ff <= rw_ff;
         row_ff  <= '0;
         rlo_ff  <= '0;
         rhi_ff  <= qh_ff;
         rrem_ff <= rh_ff;
      end
      if (cmd.accept) begin
         pr_ff    <= red_in;
         pg_ff    <= green_in;
         pb_ff    <= blue_in;
         band0_ff <= col_ff;
      end
      // a finished column moves the band on
      if (cmd.acc_write && col_finished) begin
         col_ff  <= col_ff + 1'b1;
         clo_ff  <= chi_ff;
         chi_ff  <= c_nhi;
         crem_ff <= c_nrem;
      end
      if (cmd.em_init) begin
         ex_ff   <= band0_ff;
         dy_ff   <= row_ff;
         tlo_ff  <= rlo_ff;
         thi_ff  <= rhi_ff;
         trem_ff <= rrem_ff;
      end
      if (cmd.next_col) begin
         ex_ff <= ex_ff + 1'b1;
      end
      if (cmd.next_row) begin
         ex_ff   <= band0_ff;
         dy_ff   <= dy_ff + 1'b1;
         tlo_ff  <= thi_ff;
         thi_ff  <= t_nhi;
         trem_ff <= t_nrem;
      end
      // step the source position at the end of a pixel
      if (cmd.advance) begin
         if (sx_wrap) begin
            sx_ff   <= '0;
            col_ff  <= '0;
            clo_ff  <= '0;
            chi_ff  <= qw_ff;
            crem_ff <= rw_ff;
            if (row_done) begin
               row_ff  <= dy_ff;
               rlo_ff  <= tlo_ff;
               rhi_ff  <= thi_ff;
               rrem_ff <= trem_ff;
            end
            if (sy_wrap) begin
               sy_ff   <= '0;
               row_ff  <= '0;
               rlo_ff  <= '0;
               rhi_ff  <= qh_ff;
               rrem_ff <= rh_ff;
            end else begin
               sy_ff <= sy_ff + 1'b1;
            end
         end else begin
            sx_ff <= sx_ff + 1'b1;
         end
      end
   end

   // column accumulator memory with valid bits
   bai_pkg::acc_entry_type mem [CANVAS_COLUMNS];
   bai_pkg::acc_entry_type rd_ff, rd_data, acc_new;
   logic [CANVAS_COLUMNS-1:0] valid_ff;
   logic                      rd_valid_ff;
   logic [CA_W-1:0]           col_addr, ex_addr, rd_addr;

   assign col_addr = col_ff[CA_W-1:0];
   assign ex_addr  = ex_ff[CA_W-1:0];
   assign rd_addr  = cmd.em_read ? ex_addr : col_addr;
   assign rd_data  = rd_valid_ff ? rd_ff : '0;

   always_comb begin
      acc_new.red   = rd_data.red + bai_pkg::SUM_W'(pr_ff);
      acc_new.green = rd_data.green + bai_pkg::SUM_W'(pg_ff);
      acc_new.blue  = rd_data.blue + bai_pkg::SUM_W'(pb_ff);
      acc_new.count = rd_data.count + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.acc_write) begin
         mem[col_addr] <= acc_new;
      end
      rd_ff       <= mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.restart) begin
         valid_ff <= '0;
      end else begin
         if (cmd.acc_write) begin
            valid_ff[col_addr] <= 1'b1;
         end
         // emitted columns start over
         if (cmd.clear_cols) begin
            for (int i = 0; i < CANVAS_COLUMNS; i++) begin
               if (CI_W'(i) >= band0_ff && CI_W'(i) < col_ff) begin
                  valid_ff[i] <= 1'b0;
               end
            end
         end
      end
   end

   // per channel averaging
   logic                     rdone, gdone, bdone;
   logic [bai_pkg::SUM_W-1:0] rquo, gquo, bquo;
   logic [bai_pkg::CNT_W-1:0] rrem_unused, grem_unused, brem_unused;
   logic                     cnt_zero_ff;

   bai_div #(.NUM_W(bai_pkg::SUM_W), .DEN_W(bai_pkg::CNT_W)) u_red_div (
      .clock (clock), .reset (reset), .start (cmd.div_start),
      .num (rd_data.red), .den (rd_data.count),
      .done (rdone), .quo (rquo), .rem (rrem_unused)
   );
   bai_div #(.NUM_W(bai_pkg::SUM_W), .DEN_W(bai_pkg::CNT_W)) u_green_div (
      .clock (clock), .reset (reset), .start (cmd.div_start),
      .num (rd_data.green), .den (rd_data.count),
      .done (gdone), .quo (gquo), .rem (grem_unused)
   );
   bai_div #(.NUM_W(bai_pkg::SUM_W), .DEN_W(bai_pkg::CNT_W)) u_blue_div (
      .clock (clock), .reset (reset), .start (cmd.div_start),
      .num (rd_data.blue), .den (rd_data.count),
      .done (bdone), .quo (bquo), .rem (brem_unused)
   );

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         cnt_zero_ff <= rd_data.count == '0;
      end
   end

   // result register
   logic                        rsp_valid_ff;
   logic [bai_pkg::COORD_W-1:0] dest_x_ff, dest_y_ff;
   logic [bai_pkg::PIX_W-1:0]   red_ff, green_ff, blue_ff;
   logic                        run_last_ff;
   logic                        last_col, more_rows;

   assign last_col  = (ex_ff + 1'b1) == col_ff;
   assign more_rows = t_nlast == sy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         dest_x_ff   <= bai_pkg::COORD_W'(ex_ff);
         dest_y_ff   <= bai_pkg::COORD_W'(dy_ff);
         red_ff      <= cnt_zero_ff ? '0 : rquo[bai_pkg::PIX_W-1:0];
         green_ff    <= cnt_zero_ff ? '0 : gquo[bai_pkg::PIX_W-1:0];
         blue_ff     <= cnt_zero_ff ? '0 : bquo[bai_pkg::PIX_W-1:0];
         run_last_ff <= last_col && !more_rows;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign dest_x    = dest_x_ff;
   assign dest_y    = dest_y_ff;
   assign red_out   = red_ff;
   assign green_out = green_ff;
   assign blue_out  = blue_ff;
   assign run_last  = run_last_ff;

   // status back to the controller
   always_comb begin
      status.sdiv_done   = sdiv_done;
      status.acc_more    = col_finished && (chi_ff <= sx_ff);
      status.emit_needed = row_done && (col_ff != band0_ff);
      status.div_done    = rdone && gdone && bdone;
      status.out_valid   = rsp_valid_ff;
      status.out_taken   = rsp_valid_ff && rsp_ready;
      status.last_col    = last_col;
      status.more_rows   = more_rows;
   end

`ifndef ASSERT_OFF
   // an emitted box always covers at least one source pixel
   a_box_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !cnt_zero_ff)
      else $error("emitted box has zero count");
   // the source position stays inside the frame while items are taken
   a_sx_in_frame: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> (sx_ff < w_eff) && (sy_ff < h_eff))
      else $error("source position outside frame");
`endif
endmodule

/* rtl/bai_ctrl.sv */
module bai_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                csr_write_enable,
   input  bai_pkg::status_type status,
   output bai_pkg::cmd_type    cmd
);
   localparam logic [3:0] S_SW   = 4'd0;
   localparam logic [3:0] S_WW   = 4'd1;
   localparam logic [3:0] S_SH   = 4'd2;
   localparam logic [3:0] S_WH   = 4'd3;
   localparam logic [3:0] S_INIT = 4'd4;
   localparam logic [3:0] S_IDLE = 4'd5;
   localparam logic [3:0] S_RD   = 4'd6;
   localparam logic [3:0] S_WR   = 4'd7;
   localparam logic [3:0] S_CHK  = 4'd8;
   localparam logic [3:0] S_ERD  = 4'd9;
   localparam logic [3:0] S_EDIV = 4'd10;
   localparam logic [3:0] S_EWT  = 4'd11;
   localparam logic [3:0] S_EOUT = 4'd12;
   localparam logic [3:0] S_END  = 4'd13;

   logic [3:0] state_ff, state_in;

   // sequencing of setup, accumulation and emission
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_SW: begin
            cmd.sdiv_start = 1'b1;
            state_in       = S_WW;
         end
         S_WW: begin
            if (status.sdiv_done) begin
               cmd.load_w = 1'b1;
               state_in   = S_SH;
            end
         end
         S_SH: begin
            cmd.sdiv_start = 1'b1;
            cmd.sdiv_sel   = 1'b1;
            state_in       = S_WH;
         end
         S_WH: begin
            cmd.sdiv_sel = 1'b1;
            if (status.sdiv_done) begin
               cmd.load_h = 1'b1;
               state_in   = S_INIT;
            end
         end
         S_INIT: begin
            cmd.restart = 1'b1;
            state_in    = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_RD;
            end
         end
         S_RD: begin
            state_in = S_WR;
         end
         S_WR: begin
            cmd.acc_write = 1'b1;
            state_in      = status.acc_more ? S_RD : S_CHK;
         end
         S_CHK: begin
            if (status.emit_needed) begin
               cmd.em_init = 1'b1;
               state_in    = S_ERD;
            end else begin
               state_in = S_END;
            end
         end
         S_ERD: begin
            cmd.em_read = 1'b1;
            state_in    = S_EDIV;
         end
         S_EDIV: begin
            cmd.div_start = 1'b1;
            state_in      = S_EWT;
         end
         S_EWT: begin
            if (status.div_done) begin
               cmd.out_load = 1'b1;
               state_in     = S_EOUT;
            end
         end
         S_EOUT: begin
            if (status.out_taken) begin
               if (!status.last_col) begin
                  cmd.next_col = 1'b1;
                  state_in     = S_ERD;
               end else if (status.more_rows) begin
                  cmd.next_row = 1'b1;
                  state_in     = S_ERD;
               end else begin
                  cmd.next_row   = 1'b1;
                  cmd.clear_cols = 1'b1;
                  state_in       = S_END;
               end
            end
         end
         S_END: begin
            cmd.advance = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_SW;
         end
      endcase
      // a register write restarts the frame setup
      if (csr_write_enable) begin
         state_in = S_SW;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SW;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef ASSERT_OFF
   // no result is pending when a new pixel can be taken
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !status.out_valid)
      else $error("result pending while idle");
   // a waiting result is always held in the result register
   a_eout_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EOUT |-> status.out_valid)
      else $error("waiting for transfer without a result");
   // a pixel transfer starts the accumulate read
   a_accept_rd: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && !csr_write_enable |=> state_ff == S_RD)
      else $error("accepted pixel not processed");
`endif
endmodule
